// File: rtl/sibd_pkg.sv
// ----------------------------------------------------------------------------
// sibd_pkg
// Shared types and constants for the signed integer to base digits converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sibd_pkg;

    localparam int MAX_RADIX  = 16;
    localparam int MAX_DIGITS = 32;
    localparam int NUM_CELLS  = MAX_DIGITS;
    localparam int MAG_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int DIGIT_W    = $clog2(MAX_RADIX);
    localparam int RADIX_W    = DIGIT_W + 1;
    localparam int CNT_W      = $clog2(NUM_CELLS + MAG_W);
    localparam int REM_W      = $clog2(NUM_CELLS + 1);

    typedef logic [DIGIT_W-1:0]   digit_t;
    typedef logic [RADIX_W-1:0]   radix_t;
    typedef logic [CHAR_W-1:0]    char_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CNT_W-1:0]     count_t;
    typedef logic [REM_W-1:0]     rem_t;

    // last cycle of conversion: final bit reaches the top cell
    localparam count_t CONV_LAST  = CNT_W'(MAG_W + NUM_CELLS - 2);
    localparam count_t FEED_COUNT = CNT_W'(MAG_W);
    localparam rem_t   REM_FULL   = REM_W'(NUM_CELLS);
    localparam rem_t   REM_ONE    = REM_W'(1);

    localparam char_t SIGN_PLUS  = 8'h2B;
    localparam char_t SIGN_MINUS = 8'h2D;
    localparam char_t CHAR_NUL   = 8'h00;

    localparam cfg_idx_t REG_BASE_LENGTH   = 2'd0;
    localparam cfg_idx_t REG_ALPHABET_LOW  = 2'd1;
    localparam cfg_idx_t REG_ALPHABET_HIGH = 2'd2;

    localparam radix_t          RESET_BASE_LENGTH = 5'd10;
    localparam logic [CFG_W-1:0] RESET_ALPHA_LOW  = 64'h3736353433323130;
    localparam logic [CFG_W-1:0] RESET_ALPHA_HIGH = 64'h0000000000003938;

    typedef struct packed {
        logic valid;
        logic data;
    } carry_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/sibd_in_if.sv
// ----------------------------------------------------------------------------
// sibd_in_if
// Input channel: one signed value per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface sibd_in_if;
    import sibd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/sibd_out_if.sv
// ----------------------------------------------------------------------------
// sibd_out_if
// Output channel: one character per beat, last marks the end of a value.
// ----------------------------------------------------------------------------
`default_nettype none

interface sibd_out_if;
    import sibd_pkg::*;

    logic  valid;
    logic  ready;
    char_t character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/sibd_cell.sv
// ----------------------------------------------------------------------------
// sibd_cell
// One digit cell: doubles its digit and adds the incoming carry modulo the
// radix, passing the overflow to the next cell through a register.
// ----------------------------------------------------------------------------
`default_nettype none

module sibd_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sibd_pkg::cell_ctrl_t ctrl,
    input  sibd_pkg::radix_t     radix,
    input  sibd_pkg::carry_t     carry_in,
    input  sibd_pkg::digit_t     digit_in,
    output sibd_pkg::carry_t     carry_out,
    output sibd_pkg::digit_t     digit
);
    import sibd_pkg::*;

    digit_t digit_reg;
    digit_t digit_next;
    carry_t carry_reg;
    carry_t carry_next;
    radix_t dbl;
    radix_t dbl_sub;
    logic   geq;

    always_comb
    begin
        dbl     = {digit_reg, carry_in.data};
        geq     = (dbl >= radix);
        dbl_sub = dbl - radix;
    end

    always_comb
    begin
        digit_next = digit_reg;
        carry_next = '0;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
        else
        begin
            carry_next.valid = carry_in.valid;
            carry_next.data  = carry_in.valid & geq;
            if (carry_in.valid)
            begin
                digit_next = geq ? dbl_sub[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
            carry_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
            carry_reg <= carry_next;
        end
    end

    assign digit     = digit_reg;
    assign carry_out = carry_reg;

endmodule

`default_nettype wire

// File: rtl/signed_int_to_base_digits.sv
// ----------------------------------------------------------------------------
// signed_int_to_base_digits
// Signed 32-bit integer to character string in a configurable base.
// ----------------------------------------------------------------------------
// One value is taken at a time. The magnitude streams bit by bit, MSB first,
// into a row of 32 digit cells; each cell's carry reaches its neighbor
// through a register. The cells then shift toward the top cell: leading
// zero digits drop out at one per cycle, and each character (sign first
// when negative) leaves in one beat. With an invalid alphabet the value is
// taken and nothing is produced.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_base_digits (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  sibd_pkg::cfg_idx_t cfg_index,
    input  logic [63:0]        cfg_data,
    sibd_in_if.sink            num,
    sibd_out_if.source         chars
);
    import sibd_pkg::*;

    radix_t           base_length_reg;
    logic [CFG_W-1:0] alphabet_low_reg;
    logic [CFG_W-1:0] alphabet_high_reg;

    state_t           state_reg;
    state_t           state_next;
    logic [MAG_W-1:0] mag_reg;
    logic [MAG_W-1:0] mag_next;
    logic             neg_reg;
    logic             neg_next;
    count_t           count_reg;
    count_t           count_next;
    rem_t             rem_reg;
    rem_t             rem_next;

    logic [2*CFG_W-1:0] alpha_all;
    char_t              entry [MAX_RADIX];
    logic               alpha_ok;
    logic               accept;
    logic               top_zero;
    logic               skip_shift;
    logic               emit_shift;

    cell_ctrl_t ctrl;
    carry_t     carry [NUM_CELLS+1];
    digit_t     digit [NUM_CELLS];
    digit_t     top_digit;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg   <= RESET_BASE_LENGTH;
            alphabet_low_reg  <= RESET_ALPHA_LOW;
            alphabet_high_reg <= RESET_ALPHA_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_LENGTH:   base_length_reg   <= cfg_data[RADIX_W-1:0];
                REG_ALPHABET_LOW:  alphabet_low_reg  <= cfg_data;
                REG_ALPHABET_HIGH: alphabet_high_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign alpha_all = {alphabet_high_reg, alphabet_low_reg};

    always_comb
    begin
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            entry[i] = alpha_all[i*CHAR_W +: CHAR_W];
        end
    end

    // alphabet check: length, forbidden bytes, duplicates among used entries
    always_comb
    begin
        alpha_ok = (base_length_reg >= RADIX_W'(2)) &&
                   (base_length_reg <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            if (RADIX_W'(i) < base_length_reg)
            begin
                if (entry[i] == CHAR_NUL || entry[i] == SIGN_PLUS ||
                    entry[i] == SIGN_MINUS)
                begin
                    alpha_ok = 1'b0;
                end
            end
            for (int j = i + 1; j < MAX_RADIX; j++)
            begin
                if (RADIX_W'(j) < base_length_reg && entry[i] == entry[j])
                begin
                    alpha_ok = 1'b0;
                end
            end
        end
    end

    // cell row
    assign carry[0].valid = (state_reg == ST_CONV) && (count_reg < FEED_COUNT);
    assign carry[0].data  = mag_reg[MAG_W-1];

    generate
        for (genvar k = 0; k < NUM_CELLS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                sibd_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (ctrl),
                    .radix     (base_length_reg),
                    .carry_in  (carry[k]),
                    .digit_in  ('0),
                    .carry_out (carry[k+1]),
                    .digit     (digit[k])
                );
            end
            else
            begin : g_rest
                sibd_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (ctrl),
                    .radix     (base_length_reg),
                    .carry_in  (carry[k]),
                    .digit_in  (digit[k-1]),
                    .carry_out (carry[k+1]),
                    .digit     (digit[k])
                );
            end
        end
    endgenerate

    assign top_digit = digit[NUM_CELLS-1];
    assign top_zero  = (top_digit == '0);

    // control
    assign accept     = num.valid && num.ready;
    assign skip_shift = (state_reg == ST_SKIP) && top_zero && (rem_reg > REM_ONE);
    assign emit_shift = (state_reg == ST_EMIT) && chars.ready;

    always_comb
    begin
        ctrl.clear = accept && alpha_ok;
        ctrl.shift = skip_shift || emit_shift;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (num.valid && alpha_ok)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (count_reg == CONV_LAST)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                if (chars.ready)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!skip_shift)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (chars.ready && rem_reg == REM_ONE)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        if (accept)
        begin
            neg_next   = num.value[VALUE_W-1];
            mag_next   = num.value[VALUE_W-1] ? (MAG_W'(0) - MAG_W'(num.value))
                                              : MAG_W'(num.value);
            count_next = '0;
        end
        else if (state_reg == ST_CONV)
        begin
            mag_next   = {mag_reg[MAG_W-2:0], 1'b0};
            count_next = count_reg + CNT_W'(1);
            rem_next   = REM_FULL;
        end
        else if (ctrl.shift)
        begin
            rem_next = rem_reg - REM_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
        end
    end

    // outputs
    always_comb
    begin
        num.ready       = (state_reg == ST_IDLE);
        chars.valid     = 1'b0;
        chars.character = alpha_all[{top_digit, 3'b000} +: CHAR_W];
        chars.last      = 1'b0;
        case (state_reg)
            ST_SIGN:
            begin
                chars.valid     = 1'b1;
                chars.character = SIGN_MINUS;
            end
            ST_EMIT:
            begin
                chars.valid = 1'b1;
                chars.last  = (rem_reg == REM_ONE);
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
